FILE: hdl/byte_level_token_decoder_assert.svh
// Assertion macros of the byte-level token decoder, used by btd_outq.
`ifndef BYTE_LEVEL_TOKEN_DECODER_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_DECODER_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define BTD_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define BTD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

FILE: hdl/btd_pkg.sv
// Types, constants and decode functions of the byte-level token decoder.
`timescale 1ns / 1ps
package btd_pkg;

   // Most results that one input byte can cause.
   localparam int unsigned GRP_MAX = 3;
   localparam int unsigned GRP_CNT_W = 2;

   // Lead byte classification masks and patterns.
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;

   // Ranges of code points that map to themselves.
   localparam logic [20:0] SELF0_LO = 21'd33;
   localparam logic [20:0] SELF0_HI = 21'd126;
   localparam logic [20:0] SELF1_LO = 21'h0000A1;
   localparam logic [20:0] SELF1_HI = 21'h0000AC;
   localparam logic [20:0] SELF2_LO = 21'h0000AE;
   localparam logic [20:0] SELF2_HI = 21'h0000FF;

   // Shifted range that maps back to the unused bytes.
   localparam logic [20:0] EXT_BASE  = 21'd256;
   localparam logic [20:0] EXT_END   = 21'd324;
   localparam logic [6:0]  EXT_SPLIT0 = 7'd33;
   localparam logic [6:0]  EXT_SPLIT1 = 7'd67;
   localparam logic [7:0]  EXT_OFFSET = 8'd94;
   localparam logic [7:0]  EXT_LAST_BYTE = 8'hAD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       token_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       token_end;
   } rsp_type;

   // Results of one input byte, packed from entry 0 upward.
   typedef struct packed {
      logic [GRP_CNT_W-1:0]      count;
      rsp_type [GRP_MAX-1:0]     entry;
   } grp_type;

   // Sequence length that a lead byte asks for; stray bytes stand alone.
   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      if (!c[7]) len = 3'd1;
      else if ((c & LEAD2_MASK) == LEAD2_PAT) len = 3'd2;
      else if ((c & LEAD3_MASK) == LEAD3_PAT) len = 3'd3;
      else if ((c & LEAD4_MASK) == LEAD4_PAT) len = 3'd4;
      else len = 3'd1;
      return len;
   endfunction

   // Code point from len bytes; continuation bytes give their low six bits.
   function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] len);
      logic [20:0] cp;
      case (len)
         3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
         3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
         default: cp = {13'd0, b0};
      endcase
      return cp;
   endfunction

   // Inverse byte-level table: bit 8 flags a mapped code point.
   function automatic logic [8:0] map_cp(input logic [20:0] cp);
      logic [8:0] res;
      logic [6:0] n;
      n = 7'(cp - EXT_BASE);
      if ((cp >= SELF0_LO && cp <= SELF0_HI) || (cp >= SELF1_LO && cp <= SELF1_HI) ||
          (cp >= SELF2_LO && cp <= SELF2_HI)) begin
         res = {1'b1, cp[7:0]};
      end else if (cp >= EXT_BASE && cp < EXT_END) begin
         if (n < EXT_SPLIT0) res = {1'b1, 1'b0, n};
         else if (n < EXT_SPLIT1) res = {1'b1, 8'({1'b0, n} + EXT_OFFSET)};
         else res = {1'b1, EXT_LAST_BYTE};
      end else begin
         res = 9'd0;
      end
      return res;
   endfunction

endpackage

FILE: hdl/btd_decode.sv
// Sequence state and single-pass decode of one byte into a result group.
`timescale 1ns / 1ps
module btd_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  btd_pkg::req_type in_data,
   output btd_pkg::grp_type grp
);

   logic [7:0] pend_ff [0:2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [2:0] seqlen_ff;
   logic [2:0] seqlen_in;

   logic [7:0] b0, b1, b2, b3;
   logic [2:0] seqlen;
   logic [2:0] n;
   logic       complete;
   logic [8:0] cand [0:2];

   // Bytes of the open sequence with the new byte in its slot.
   always_comb begin
      b0 = (count_ff == 2'd0) ? in_data.in_byte : pend_ff[0];
      b1 = (count_ff == 2'd1) ? in_data.in_byte : pend_ff[1];
      b2 = (count_ff == 2'd2) ? in_data.in_byte : pend_ff[2];
      b3 = in_data.in_byte;
      seqlen = (count_ff == 2'd0) ? btd_pkg::lead_length(in_data.in_byte) : seqlen_ff;
      n = {1'b0, count_ff} + 3'd1;
      complete = (n >= seqlen);
   end

   // Candidate code points. A token that ends inside a sequence lets the lead
   // byte stand alone and parses the remaining bytes again.
   always_comb begin
      cand[0] = 9'd0;
      cand[1] = 9'd0;
      cand[2] = 9'd0;
      if (complete) begin
         cand[0] = btd_pkg::map_cp(btd_pkg::assemble(b0, b1, b2, b3, n));
      end else if (in_data.token_last) begin
         cand[0] = btd_pkg::map_cp({13'd0, b0});
         if (n == 3'd3) begin
            if (btd_pkg::lead_length(b1) == 3'd2) begin
               cand[1] = btd_pkg::map_cp(btd_pkg::assemble(b1, b2, 8'd0, 8'd0, 3'd2));
            end else begin
               cand[1] = btd_pkg::map_cp({13'd0, b1});
               cand[2] = btd_pkg::map_cp({13'd0, b2});
            end
         end else if (n == 3'd2) begin
            cand[1] = btd_pkg::map_cp({13'd0, b1});
         end
      end
   end

   // Pack mapped candidates, add the bare end marker and the end flags.
   always_comb begin
      logic [1:0] k;
      k = 2'd0;
      grp = '0;
      for (int i = 0; i < btd_pkg::GRP_MAX; i++) begin
         if (cand[i][8]) begin
            grp.entry[k].out_byte = cand[i][7:0];
            grp.entry[k].byte_valid = 1'b1;
            k = k + 2'd1;
         end
      end
      if (in_data.token_last && k == 2'd0) begin
         k = 2'd1;
      end
      if (k != 2'd0) begin
         grp.entry[k - 2'd1].run_last = 1'b1;
         grp.entry[k - 2'd1].token_end = in_data.token_last;
      end
      grp.count = k;
   end

   // Next sequence state.
   always_comb begin
      if (in_data.token_last || complete) begin
         count_in = 2'd0;
         seqlen_in = 3'd0;
      end else begin
         count_in = n[1:0];
         seqlen_in = seqlen;
      end
   end

   // Pending bytes hold payload only.
   always_ff @(posedge clock) begin
      if (step && !in_data.token_last && !complete) begin
         pend_ff[count_ff] <= in_data.in_byte;
      end
   end

   // Sequence control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         seqlen_ff <= 3'd0;
      end else if (step) begin
         count_ff <= count_in;
         seqlen_ff <= seqlen_in;
      end
   end

endmodule

FILE: hdl/btd_outq.sv
// Result group register that hands out one result per transaction.
`timescale 1ns / 1ps
`include "byte_level_token_decoder_assert.svh"
module btd_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   input  btd_pkg::grp_type load_grp,
   output logic             load_ready,
   output logic             rsp_valid,
   output btd_pkg::rsp_type rsp_data,
   input  logic             rsp_ready
);

   logic                            valid_ff;
   logic                            valid_in;
   logic [btd_pkg::GRP_CNT_W-1:0]   cnt_ff;
   logic [btd_pkg::GRP_CNT_W-1:0]   cnt_in;
   btd_pkg::rsp_type [btd_pkg::GRP_MAX-1:0] ent_ff;
   btd_pkg::rsp_type [btd_pkg::GRP_MAX-1:0] ent_in;
   logic                            take;
   logic                            free;

   // The register is free when empty or when its final result leaves now.
   assign take = valid_ff && rsp_ready;
   assign free = !valid_ff || (take && cnt_ff == 2'd1);
   assign load_ready = free;
   assign rsp_valid = valid_ff;
   assign rsp_data = ent_ff[0];

   // Load a new group or shift the remaining results toward the head.
   always_comb begin
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      ent_in = ent_ff;
      if (load_valid && free) begin
         valid_in = (load_grp.count != '0);
         cnt_in = load_grp.count;
         ent_in = load_grp.entry;
      end else if (take) begin
         valid_in = (cnt_ff != 2'd1);
         cnt_in = cnt_ff - 2'd1;
         for (int i = 0; i < btd_pkg::GRP_MAX - 1; i++) begin
            ent_in[i] = ent_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff <= cnt_in;
      end
   end

   `BTD_ASSERT_IMPLY(a_cnt_nonzero, clock, reset, valid_ff, cnt_ff != 2'd0, "held group is empty")
   `BTD_ASSERT_IMPLY(a_final_run_last, clock, reset, valid_ff && cnt_ff == 2'd1, ent_ff[0].run_last, "final result lacks run_last")
   `BTD_ASSERT_IMPLY(a_bare_marker, clock, reset, valid_ff && !ent_ff[0].byte_valid, ent_ff[0].token_end && ent_ff[0].run_last, "bare marker outside token end")
   `BTD_ASSERT_NEXT(a_group_drains, clock, reset, take && cnt_ff > 2'd1, valid_ff, "group lost results")

endmodule

FILE: hdl/byte_level_token_decoder.sv
// Top level of the byte-level token decoder.
//
// Usage: raw UTF-8 bytes of vocabulary tokens enter on the req_ channel, one
// byte per transaction, with token_last set on each token's final byte. Each
// decoded byte leaves on the rsp_ channel as one transaction; a token that
// ends with no byte produced gives one bare end marker (byte_valid low).
// Path: a byte accepted into the input register is decoded combinationally
// and loaded into the result group register, from which its first result
// is offered on the rsp_ channel.
// Throughput: one input byte per cycle while each byte causes at most one
// result and the receiver is ready. A byte that causes two or three results
// holds the group register until the single rsp_ port has drained the group.
// Bytes that cause no result pass through without waiting for the group.
// Reset clears the open sequence and drops all held transactions.
// When the receiver stalls, the group register holds its results and the
// input register takes one more byte before req_ready goes low.
`timescale 1ns / 1ps
module byte_level_token_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  btd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output btd_pkg::rsp_type rsp_data
);

   logic             in_valid_ff;
   logic             in_valid_in;
   btd_pkg::req_type in_data_ff;
   btd_pkg::grp_type grp;
   logic             load_valid;
   logic             load_ready;
   logic             move;

   // The held byte moves on when it yields nothing or the group is free.
   assign load_valid = in_valid_ff && (grp.count != '0);
   assign move = in_valid_ff && ((grp.count == '0) || load_ready);
   assign req_ready = !in_valid_ff || move;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Decode of the held byte against the open sequence.
   btd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (move),
      .in_data (in_data_ff),
      .grp     (grp)
   );

   // Result group register and output serializer.
   btd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_grp   (grp),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_ready  (rsp_ready)
   );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the byte-level token decoder.
`timescale 1ns / 1ps
module testbench;

   // Cycles with no transaction on either channel before the run is abandoned.
   localparam int unsigned STALL_LIMIT = 2000;

   // One row of stimulus, with a hand-written result where it is obvious.
   typedef struct packed {
      btd_pkg::req_type item;
      logic             known;
      btd_pkg::rsp_type want;
   } stim_row_type;

   // Hand-written result that travels with each byte until it is accepted.
   typedef struct {
      logic             known;
      btd_pkg::rsp_type want;
   } hint_type;

   localparam btd_pkg::rsp_type NO_RSP = '0;
   localparam btd_pkg::rsp_type BARE_END = '{8'h00, 1'b0, 1'b1, 1'b1};

   // Directed bytes: extremes, stray bytes, every sequence length, tokens that
   // end inside a sequence, unmapped code points and bare end markers.
   localparam stim_row_type DIRECTED_ROWS [27] = '{
      '{'{8'h41, 1'b0}, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0}},
      '{'{8'h7E, 1'b1}, 1'b1, '{8'h7E, 1'b1, 1'b1, 1'b1}},
      '{'{8'h20, 1'b1}, 1'b1, BARE_END},
      '{'{8'h00, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
      '{'{8'hAD, 1'b1}, 1'b1, BARE_END},
      '{'{8'hBF, 1'b0}, 1'b1, '{8'hBF, 1'b1, 1'b1, 1'b0}},
      '{'{8'hF8, 1'b0}, 1'b1, '{8'hF8, 1'b1, 1'b1, 1'b0}},
      '{'{8'hC4, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h80, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{'{8'hC5, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h83, 1'b1}, 1'b1, '{8'hAD, 1'b1, 1'b1, 1'b1}},
      '{'{8'hE0, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h84, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h80, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hF7, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hBF, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hBF, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hBF, 1'b1}, 1'b1, BARE_END},
      '{'{8'hF0, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h41, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h42, 1'b1}, 1'b0, NO_RSP},
      '{'{8'hE5, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hA5, 1'b1}, 1'b0, NO_RSP},
      '{'{8'hC3, 1'b1}, 1'b1, '{8'hC3, 1'b1, 1'b1, 1'b1}},
      '{'{8'hC2, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h41, 1'b1}, 1'b0, NO_RSP}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   btd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   btd_pkg::rsp_type rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned error_count = 0;

   stim_row_type     stim_rows[$];
   hint_type         byte_hints[$];
   btd_pkg::rsp_type expected_bytes[$];

   // Decoder state as the predictor sees it.
   logic [7:0]       held_bytes[4];
   logic [2:0]       held_count;
   logic [2:0]       want_length;
   btd_pkg::rsp_type decoded[4];
   int unsigned      decoded_count;

   byte_level_token_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial forever #10 clock = ~clock;

   // Sequence length requested by a byte in lead position.
   function automatic logic [2:0] lead_len(logic [7:0] c);
      casez (c)
         8'b0???????: return 3'd1;
         8'b110?????: return 3'd2;
         8'b1110????: return 3'd3;
         8'b11110???: return 3'd4;
         default:     return 3'd1;
      endcase
   endfunction

   // Code point built from len held bytes starting at pos.
   function automatic logic [20:0] code_point_at(int unsigned pos, int unsigned len);
      logic [20:0] cp;
      logic [7:0]  lead;
      int unsigned i;
      lead = held_bytes[pos & 3];
      case (len)
         2:       cp = 21'(lead[4:0]);
         3:       cp = 21'(lead[3:0]);
         4:       cp = 21'(lead[2:0]);
         default: cp = 21'(lead);
      endcase
      for (i = 1; i < len; i++) begin
         cp = (cp << 6) | 21'(held_bytes[(pos + i) & 3][5:0]);
      end
      return cp;
   endfunction

   // Map a code point back to its raw byte and queue it; unmapped points vanish.
   function automatic void emit_code_point(logic [20:0] cp);
      int unsigned idx;
      logic [7:0]  b;
      logic        hit;
      hit = 1'b1;
      b = 8'h00;
      if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'hA1 && cp <= 21'hAC) ||
          (cp >= 21'hAE && cp <= 21'hFF)) begin
         b = cp[7:0];
      end else if (cp >= 21'd256 && cp < 21'd324) begin
         idx = cp - 21'd256;
         if (idx < 33) b = 8'(idx);
         else if (idx < 67) b = 8'(idx + 94);
         else b = 8'hAD;
      end else begin
         hit = 1'b0;
      end
      if (hit && decoded_count < 4) begin
         decoded[decoded_count] = '{b, 1'b1, 1'b0, 1'b0};
         decoded_count++;
      end
   endfunction

   // Advance the state by one byte and fill decoded[] with its results.
   function automatic void predict_decode(btd_pkg::req_type r);
      int unsigned n;
      int unsigned pos;
      int unsigned len;
      logic [7:0]  c;
      decoded_count = 0;
      if (held_count == 3'd0) want_length = lead_len(r.in_byte);
      held_bytes[held_count[1:0]] = r.in_byte;
      n = int'(held_count[1:0]) + 1;
      if (!r.token_last) begin
         if (n >= want_length || n >= 4) begin
            emit_code_point(code_point_at(0, n));
            held_count = 3'd0;
            want_length = 3'd0;
         end else begin
            held_count = 3'(n);
         end
      end else begin
         // The token ends here: split whatever is held into code points anew.
         pos = 0;
         while (pos < n) begin
            c = held_bytes[pos & 3];
            len = lead_len(c);
            if (len > 1 && pos + len <= n) begin
               emit_code_point(code_point_at(pos, len));
               pos += len;
            end else begin
               emit_code_point(21'(c));
               pos += 1;
            end
         end
         if (decoded_count == 0) begin
            decoded[0] = '0;
            decoded_count = 1;
         end
         decoded[decoded_count - 1].token_end = 1'b1;
         held_count = 3'd0;
         want_length = 3'd0;
      end
      if (decoded_count > 0) decoded[decoded_count - 1].run_last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function automatic void add_row(logic [7:0] b, logic last);
      stim_rows.insert(stim_rows.size(), '{'{b, last}, 1'b0, NO_RSP});
   endfunction

   // Append random tokens, mostly well-formed UTF-8 aimed at the mapped ranges,
   // with truncated tokens, broken sequences and loose noise bytes mixed in.
   function automatic void add_random(int unsigned count);
      logic [7:0]  tok[$];
      logic [7:0]  lead;
      int unsigned goal;
      int unsigned keep;
      int unsigned i;
      goal = stim_rows.size() + count;
      while (stim_rows.size() < goal) begin
         tok.delete();
         if ($urandom_range(0, 9) == 0) begin
            add_row(8'($urandom), 1'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 7))
                  0, 1: tok.insert(tok.size(), 8'($urandom_range(0, 127)));
                  2: tok.insert(tok.size(), 8'($urandom_range(161, 255)));
                  3: begin
                     tok.insert(tok.size(), 8'hC0 | 8'($urandom_range(0, 31)));
                     tok.insert(tok.size(), 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  4: begin
                     tok.insert(tok.size(), 8'hC4 | 8'($urandom_range(0, 1)));
                     tok.insert(tok.size(), 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  5: begin
                     lead = $urandom_range(0, 1) ? 8'hE0 : 8'hE0 | 8'($urandom_range(0, 15));
                     tok.insert(tok.size(), lead);
                     tok.insert(tok.size(),
                                (lead == 8'hE0) ? 8'h84 | 8'($urandom_range(0, 1))
                                                : 8'h80 | 8'($urandom_range(0, 63)));
                     tok.insert(tok.size(), 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  6: begin
                     lead = $urandom_range(0, 1) ? 8'hF0 : 8'hF0 | 8'($urandom_range(0, 7));
                     tok.insert(tok.size(), lead);
                     tok.insert(tok.size(), 8'h80 | 8'($urandom_range(0, 63)));
                     tok.insert(tok.size(),
                                (lead == 8'hF0) ? 8'h84 | 8'($urandom_range(0, 1))
                                                : 8'h80 | 8'($urandom_range(0, 63)));
                     tok.insert(tok.size(), 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  default: begin
                     // Lead byte followed by arbitrary bytes in place of continuations.
                     tok.insert(tok.size(), 8'($urandom_range(8'hC0, 8'hF7)));
                     repeat ($urandom_range(1, 3)) tok.insert(tok.size(), 8'($urandom));
                  end
               endcase
            end
            keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, tok.size()) : tok.size();
            for (i = 0; i < keep; i++) begin
               add_row(tok[i], i == keep - 1);
            end
         end
      end
   endfunction

   // Present every queued row as one transaction, with random gaps before it.
   task automatic run_rows();
      foreach (stim_rows[i]) begin
         byte_hints.insert(byte_hints.size(), '{stim_rows[i].known, stim_rows[i].want});
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data <= stim_rows[i].item;
         do @(posedge clock); while (!(req_valid && req_ready));
         @(negedge clock);
      end
      stim_rows.delete();
   endtask

   // Hold the sender off until every expected result has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_bytes.size() != 0);
   endtask

   // Receiver readiness, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Score results against expectations and predict each accepted byte.
   always @(posedge clock) begin
      hint_type         hint;
      btd_pkg::rsp_type want;
      if (reset) begin
         held_count = 3'd0;
         want_length = 3'd0;
         foreach (held_bytes[i]) held_bytes[i] = 8'h00;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_data.byte_valid));
               check_field("run_last", 8'(want.run_last), 8'(rsp_data.run_last));
               check_field("token_end", 8'(want.token_end), 8'(rsp_data.token_end));
            end
         end
         if (req_valid && req_ready) begin
            hint = byte_hints.pop_front();
            predict_decode(req_data);
            if (hint.known) begin
               expected_bytes.insert(expected_bytes.size(), hint.want);
            end else begin
               for (int unsigned i = 0; i < decoded_count; i++) begin
                  expected_bytes.insert(expected_bytes.size(), decoded[i]);
               end
            end
         end
      end
   end

   // Abandon the run when no transaction moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Main sequence: reset, then three random phases, the first led by the directed rows.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender mostly busy, receiver mostly stalled.
      send_idle_pct = 6;
      recv_idle_pct = 70;
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         stim_rows.insert(stim_rows.size(), DIRECTED_ROWS[i]);
      end
      add_random(30);
      run_rows();
      drain_results();

      // Sender mostly idle, receiver mostly ready.
      send_idle_pct = 70;
      recv_idle_pct = 6;
      add_random(30);
      run_rows();
      drain_results();

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(30);
      run_rows();
      req_valid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
